[rtl/rotoff_pkg.sv]
`default_nettype none

package rotoff_pkg;

    localparam int WORD_BITS = 32;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_INV  = 2'd1;
    localparam logic [1:0] ST_BAD_MOD = 2'd2;

    typedef struct packed {
        logic [WORD_BITS-1:0] f_at_root;
        logic [WORD_BITS-1:0] g_at_root;
        logic [WORD_BITS-1:0] root;
        logic [WORD_BITS-1:0] rotation_u;
        logic [WORD_BITS-1:0] modulus;
    } rot_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] offset_v;
        logic [1:0]           status;
    } rot_result_t;

endpackage

`default_nettype wire

[rtl/rotation_offset_mod_p.sv]
`default_nettype none

// rotation offset solver: one transaction in, one result out. a transaction is taken
// at a clock edge with start high and busy low; for a modulus of two or more, busy
// then stays high until the cycle in which the result is shown. the result stands on
// the result port for exactly one cycle with done high, and the receiver cannot stall
// it, so it must capture the result in that cycle. reductions and divisions share
// one shift-and-subtract divider and multiplies use a double-and-add unit, under a
// small sequencer: four reductions mod p, one zero check, one long division plus one
// euclid update for each step of the extended euclidean algorithm (at most about
// 1.44*WORD_BITS steps), one gcd check, and three modular multiplies with one add
// step between the second and the third. a modulus below two is answered in the
// cycle right after it is taken.
module rotation_offset_mod_p
    import rotoff_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire rot_item_t   item,
    output logic             busy,
    output logic             done,
    output rot_result_t      result
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);
    localparam int SW = W + 2;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RED    = 3'd1;  // reduce one operand mod p
    localparam logic [2:0] S_GCHK   = 3'd2;  // zero check on g, set up euclid
    localparam logic [2:0] S_DIV    = 3'd3;  // long division r0 / r1
    localparam logic [2:0] S_EUC    = 3'd4;  // euclid remainder and coefficient update
    localparam logic [2:0] S_INVEND = 3'd5;  // gcd check, fold inverse into 0..p-1
    localparam logic [2:0] S_MUL    = 3'd6;  // double-and-add modular multiply
    localparam logic [2:0] S_ADDF   = 3'd7;  // add f, negate

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [1:0]          red_idx_reg, red_idx_next;
    logic [1:0]          mul_idx_reg, mul_idx_next;

    logic [W-1:0]        p_reg, p_next;
    logic [W-1:0]        f_reg, f_next;
    logic [W-1:0]        g_reg, g_next;
    logic [W-1:0]        r_reg, r_next;
    logic [W-1:0]        u_reg, u_next;

    // shared divider: dividend shifts out msb first
    logic [W-1:0]        n_reg, n_next;
    logic [W-1:0]        d_reg, d_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic signed [SW-1:0] qs_reg, qs_next;   // running q * s1

    // euclid
    logic [W-1:0]        r0_reg, r0_next;
    logic [W-1:0]        r1_reg, r1_next;
    logic signed [SW-1:0] s0_reg, s0_next;
    logic signed [SW-1:0] s1_reg, s1_next;
    logic [W-1:0]        inv_reg, inv_next;

    // modular multiply
    logic [W-1:0]        mac_reg, mac_next;
    logic [W-1:0]        ma_reg, ma_next;
    logic [W-1:0]        mb_reg, mb_next;

    logic                done_reg, done_next;
    rot_result_t         result_reg, result_next;

    // divider step
    logic [W:0]          trial;
    logic                q_bit;
    logic [W-1:0]        rem_step;
    logic signed [SW-1:0] qs_step;

    // multiply step
    logic [W:0]          dbl;
    logic [W-1:0]        dbl_red;
    logic [W:0]          sum;
    logic [W-1:0]        sum_red;
    logic [W-1:0]        mac_step;

    // add f and negate
    logic [W:0]          tsum;
    logic [W-1:0]        t_val;
    logic [W-1:0]        neg_t;
    logic signed [SW-1:0] inv_fold;

    logic                last;

    assign last = (cnt_reg == CW'(1));

    always_comb
    begin
        trial    = {rem_reg, n_reg[W-1]};
        q_bit    = (trial >= {1'b0, d_reg});
        rem_step = q_bit ? W'(trial - {1'b0, d_reg}) : trial[W-1:0];
        qs_step  = (qs_reg <<< 1) + (q_bit ? s1_reg : SW'(0));
    end

    always_comb
    begin
        dbl      = {mac_reg, 1'b0};
        dbl_red  = (dbl >= {1'b0, p_reg}) ? W'(dbl - {1'b0, p_reg}) : dbl[W-1:0];
        sum      = {1'b0, dbl_red} + {1'b0, ma_reg};
        sum_red  = (sum >= {1'b0, p_reg}) ? W'(sum - {1'b0, p_reg}) : sum[W-1:0];
        mac_step = mb_reg[W-1] ? sum_red : dbl_red;
    end

    always_comb
    begin
        tsum     = {1'b0, mac_reg} + {1'b0, f_reg};
        t_val    = (tsum >= {1'b0, p_reg}) ? W'(tsum - {1'b0, p_reg}) : tsum[W-1:0];
        neg_t    = (t_val == '0) ? '0 : W'(p_reg - t_val);
        inv_fold = s0_reg[SW-1] ? (s0_reg + $signed({2'b00, p_reg})) : s0_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        red_idx_next = red_idx_reg;
        mul_idx_next = mul_idx_reg;
        p_next       = p_reg;
        f_next       = f_reg;
        g_next       = g_reg;
        r_next       = r_reg;
        u_next       = u_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        rem_next     = rem_reg;
        qs_next      = qs_reg;
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        s0_next      = s0_reg;
        s1_next      = s1_reg;
        inv_next     = inv_reg;
        mac_next     = mac_reg;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    p_next = item.modulus;
                    f_next = item.f_at_root;
                    g_next = item.g_at_root;
                    r_next = item.root;
                    u_next = item.rotation_u;
                    if (item.modulus < W'(2))
                    begin
                        done_next   = 1'b1;
                        result_next = '{offset_v: '0, status: ST_BAD_MOD};
                    end
                    else
                    begin
                        n_next       = item.f_at_root;
                        d_next       = item.modulus;
                        rem_next     = '0;
                        qs_next      = '0;
                        cnt_next     = CW'(W);
                        red_idx_next = 2'd0;
                        state_next   = S_RED;
                    end
                end
            end

            S_RED:
            begin
                n_next   = n_reg << 1;
                rem_next = rem_step;
                cnt_next = cnt_reg - CW'(1);
                if (last)
                begin
                    rem_next = '0;
                    cnt_next = CW'(W);
                    case (red_idx_reg)
                        2'd0:
                        begin
                            f_next = rem_step;
                            n_next = g_reg;
                        end
                        2'd1:
                        begin
                            g_next = rem_step;
                            n_next = r_reg;
                        end
                        2'd2:
                        begin
                            r_next = rem_step;
                            n_next = u_reg;
                        end
                        default:
                        begin
                            u_next = rem_step;
                        end
                    endcase
                    red_idx_next = red_idx_reg + 2'd1;
                    if (red_idx_reg == 2'd3)
                    begin
                        state_next = S_GCHK;
                    end
                end
            end

            S_GCHK:
            begin
                if (g_reg == '0)
                begin
                    done_next   = 1'b1;
                    result_next = '{offset_v: '0, status: ST_NO_INV};
                    state_next  = S_IDLE;
                end
                else
                begin
                    r0_next    = p_reg;
                    r1_next    = g_reg;
                    s0_next    = '0;
                    s1_next    = SW'(1);
                    n_next     = p_reg;
                    d_next     = g_reg;
                    rem_next   = '0;
                    qs_next    = '0;
                    cnt_next   = CW'(W);
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                n_next   = n_reg << 1;
                rem_next = rem_step;
                qs_next  = qs_step;
                cnt_next = cnt_reg - CW'(1);
                if (last)
                begin
                    state_next = S_EUC;
                end
            end

            S_EUC:
            begin
                r0_next = r1_reg;
                r1_next = rem_reg;
                s0_next = s1_reg;
                s1_next = s0_reg - qs_reg;
                if (rem_reg == '0)
                begin
                    state_next = S_INVEND;
                end
                else
                begin
                    n_next     = r1_reg;
                    d_next     = rem_reg;
                    rem_next   = '0;
                    qs_next    = '0;
                    cnt_next   = CW'(W);
                    state_next = S_DIV;
                end
            end

            S_INVEND:
            begin
                if (r0_reg != W'(1))
                begin
                    done_next   = 1'b1;
                    result_next = '{offset_v: '0, status: ST_NO_INV};
                    state_next  = S_IDLE;
                end
                else
                begin
                    inv_next     = inv_fold[W-1:0];
                    mac_next     = '0;
                    ma_next      = g_reg;
                    mb_next      = r_reg;
                    mul_idx_next = 2'd0;
                    cnt_next     = CW'(W);
                    state_next   = S_MUL;
                end
            end

            S_MUL:
            begin
                mac_next = mac_step;
                mb_next  = mb_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (last)
                begin
                    case (mul_idx_reg)
                        2'd0:
                        begin
                            // g*r done, now times u
                            ma_next      = mac_step;
                            mb_next      = u_reg;
                            mac_next     = '0;
                            cnt_next     = CW'(W);
                            mul_idx_next = 2'd1;
                        end
                        2'd1:
                        begin
                            state_next = S_ADDF;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{offset_v: mac_step, status: ST_OK};
                            state_next  = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADDF:
            begin
                ma_next      = neg_t;
                mb_next      = inv_reg;
                mac_next     = '0;
                cnt_next     = CW'(W);
                mul_idx_next = 2'd2;
                state_next   = S_MUL;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            red_idx_reg <= '0;
            mul_idx_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            red_idx_reg <= red_idx_next;
            mul_idx_reg <= mul_idx_next;
            done_reg    <= done_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        f_reg      <= f_next;
        g_reg      <= g_next;
        r_reg      <= r_next;
        u_reg      <= u_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        rem_reg    <= rem_next;
        qs_reg     <= qs_next;
        r0_reg     <= r0_next;
        r1_reg     <= r1_next;
        s0_reg     <= s0_next;
        s1_reg     <= s1_next;
        inv_reg    <= inv_next;
        mac_reg    <= mac_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        result_reg <= result_next;
    end

    // busy is low in the cycle the result is shown
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/rotoff_chk.sv]
`default_nettype none

module rotoff_chk
    import rotoff_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire rot_item_t   item,
    input wire logic        busy,
    input wire logic        done,
    input wire rot_result_t result
);

    // result cycle leaves the block free for the next transaction
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");

    // a valid modulus starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.modulus >= WORD_BITS'(2))) |=> (busy && !done))
        else $error("valid transaction not started");

    // modulus below two is answered at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.modulus < WORD_BITS'(2))) |=>
            (done && (result.status == ST_BAD_MOD)))
        else $error("small modulus not flagged");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |-> (result.offset_v == '0))
        else $error("nonzero offset on error");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.status == ST_OK) || (result.status == ST_NO_INV) ||
                  (result.status == ST_BAD_MOD)))
        else $error("unknown status");

endmodule

bind rotation_offset_mod_p rotoff_chk u_rotoff_chk
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

[test/rotation_offset_mod_p_test.sv]
`timescale 1ns / 1ps

module rotation_offset_mod_p_test;
    import rotoff_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    rot_item_t   item = '0;
    logic        busy;
    logic        done;
    rot_result_t result;

    rotation_offset_mod_p DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(item),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always #1 clk = ~clk;

    // pending input transactions, expected offsets in arrival order
    rot_item_t   pending_items[$];
    rot_result_t expected_offsets[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          stimulus_done = 1'b0;
    int          gap_left = 0;

    // a + b mod m with a, b < m
    function automatic longint unsigned mod_add(longint unsigned a, longint unsigned b,
                                                longint unsigned m);
        longint unsigned s;
        s = a + b;
        if (s >= m)
            s = s - m;
        return s;
    endfunction

    // operands fit in 32 bits, so the 64-bit product cannot overflow
    function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                                longint unsigned m);
        return (a * b) % m;
    endfunction

    // extended euclid, coefficients tracked mod m; returns 0 when gcd is not 1
    function automatic bit mod_inverse(longint unsigned b, longint unsigned m,
                                       output longint unsigned inv);
        longint unsigned r0, r1, r2, s0, s1, s2, q;
        r0 = m;
        r1 = b;
        s0 = 0;
        s1 = 1;
        inv = 0;
        while (r1 != 0)
        begin
            q = r0 / r1;
            r2 = r0 - q * r1;
            s2 = mod_add(s0, (m - mod_mul(q % m, s1, m)) % m, m);
            r0 = r1;
            r1 = r2;
            s0 = s1;
            s1 = s2;
        end
        if (r0 != 1)
            return 1'b0;
        inv = s0;
        return 1'b1;
    endfunction

    function automatic rot_result_t solve_offset(rot_item_t it);
        rot_result_t     res;
        longint unsigned p, fr, gr, rr, uu, t, inv;
        res = '0;
        p = 64'(it.modulus);
        if (p < 2)
        begin
            res.status = ST_BAD_MOD;
            return res;
        end
        fr = 64'(it.f_at_root) % p;
        gr = 64'(it.g_at_root) % p;
        rr = 64'(it.root) % p;
        uu = 64'(it.rotation_u) % p;
        if (gr == 0 || !mod_inverse(gr, p, inv))
        begin
            res.status = ST_NO_INV;
            return res;
        end
        t = mod_add(mod_mul(mod_mul(gr, rr, p), uu, p), fr, p);
        res.offset_v = 32'(mod_mul((p - t) % p, inv, p));
        res.status = ST_OK;
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // random word biased toward edges and small values
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom_range(0, 20);
            2: return 32'h8000_0000 ^ $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_modulus();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1);
            1: return $urandom_range(2, 50);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 4);
            3: return 32'hFFFF_FFFB;    // largest 32-bit prime
            4: return $urandom_range(2, 65536) * 2;    // even modulus, more shared factors
            default: return $urandom | 32'd1;
        endcase
    endfunction

    function automatic rot_item_t make_item(logic [31:0] f, logic [31:0] g, logic [31:0] r,
                                            logic [31:0] u, logic [31:0] p);
        rot_item_t it;
        it.f_at_root = f;
        it.g_at_root = g;
        it.root = r;
        it.rotation_u = u;
        it.modulus = p;
        return it;
    endfunction

    initial
    begin
        rot_item_t it;
        logic [31:0] p;
        // directed: bad modulus
        pending_items.push_back(make_item(5, 3, 7, 9, 0));
        pending_items.push_back(make_item('1, '1, '1, '1, 1));
        // smallest valid modulus
        pending_items.push_back(make_item(1, 1, 1, 1, 2));
        pending_items.push_back(make_item(0, 3, 0, 0, 2));
        // g zero mod p, both literally and by reduction
        pending_items.push_back(make_item(4, 0, 2, 3, 7));
        pending_items.push_back(make_item(4, 14, 2, 3, 7));
        // shared factor between g and p
        pending_items.push_back(make_item(1, 6, 5, 5, 9));
        pending_items.push_back(make_item(1, 32'h8000_0000, 5, 5, 32'hFFFF_FFFE));
        // all-ones and patterned fields with large moduli
        pending_items.push_back(make_item('1, '1, '1, '1, '1));
        pending_items.push_back(make_item('1, '1, '1, '1, 32'hFFFF_FFFB));
        pending_items.push_back(make_item('1, '1, '1, '1, 32'hFFFF_FFFE));
        pending_items.push_back(make_item(0, 1, 0, 0, '1));
        pending_items.push_back(make_item(0, 32'hFFFF_FFFA, '1, '1, 32'hFFFF_FFFB));
        pending_items.push_back(make_item(32'hFFFF_FFFA, 1, 0, 0, 32'hFFFF_FFFB));
        pending_items.push_back(make_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                          32'h5555_5555, 32'h8000_0001));
        pending_items.push_back(make_item(32'h5555_5555, 32'hAAAA_AAAB, 32'h5555_5555,
                                          32'hAAAA_AAAA, 32'h7FFF_FFFF));
        // random
        repeat (1250)
        begin
            p = rand_modulus();
            it = make_item(rand_word(), rand_word(), rand_word(), rand_word(), p);
            pending_items.push_back(it);
        end
        stimulus_done = 1'b1;
    end

    // driver: one transaction at a time, random gaps between them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                // transaction taken at this edge
                expected_offsets.push_back(solve_offset(item));
                gap_left <= pick_gap();
                start <= 1'b0;
            end
            else if (!start)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_items.size() > 0)
                begin
                    item <= pending_items.pop_front();
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor: result strobe lasts one cycle, capture it at that edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_offsets.size() == 0)
            begin
                $display("%0t: unexpected result offset_v=%0d status=%0d",
                         $realtime, result.offset_v, result.status);
                error_count++;
            end
            else
            begin
                rot_result_t exp_res;
                exp_res = expected_offsets.pop_front();
                if (result.offset_v !== exp_res.offset_v)
                begin
                    $display("%0t: offset_v mismatch expected %0d actual %0d",
                             $realtime, exp_res.offset_v, result.offset_v);
                    error_count++;
                end
                if (result.status !== exp_res.status)
                begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $realtime, exp_res.status, result.status);
                    error_count++;
                end
            end
        end
    end

    // run limit: covers ~1300 transactions plus gaps, many times over
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 12_000_000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (stimulus_done);
        @(posedge clk);
        while (pending_items.size() > 0 || start || busy || expected_offsets.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[rotation_offset_mod_p.f]
rtl/rotoff_pkg.sv
rtl/rotation_offset_mod_p.sv
rtl/rotoff_chk.sv
test/rotation_offset_mod_p_test.sv
